[sv/arp_pkg.sv]
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types, constants and helpers for the ARP request responder.
// ----------------------------------------------------------------------------
package arp_pkg;

    // Frame byte counter
    localparam int CNT_W = 6;
    typedef logic [CNT_W-1:0] count_t;

    localparam count_t CNT_MAX        = count_t'(63);
    localparam count_t MIN_FRAME_LEN  = count_t'(42);
    localparam count_t REPLY_LAST_IDX = count_t'(59);

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_LOCAL_IP  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_LOCAL_MAC = cfg_idx_t'(1);

    // Result kinds
    localparam logic KIND_REPLY  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // Request kinds
    localparam logic REQ_FRAME  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Frame offsets
    localparam count_t OFF_ETH_DST     = count_t'(0);
    localparam count_t OFF_ETH_SRC     = count_t'(6);
    localparam count_t OFF_ETYPE_HI    = count_t'(12);
    localparam count_t OFF_ETYPE_LO    = count_t'(13);
    localparam count_t OFF_HTYPE_HI    = count_t'(14);
    localparam count_t OFF_HTYPE_LO    = count_t'(15);
    localparam count_t OFF_PTYPE_HI    = count_t'(16);
    localparam count_t OFF_PTYPE_LO    = count_t'(17);
    localparam count_t OFF_HLEN        = count_t'(18);
    localparam count_t OFF_PLEN        = count_t'(19);
    localparam count_t OFF_OPER_HI     = count_t'(20);
    localparam count_t OFF_OPER_LO     = count_t'(21);
    localparam count_t OFF_SENDER_MAC  = count_t'(22);
    localparam count_t OFF_SENDER_IP   = count_t'(28);
    localparam count_t OFF_TARGET_MAC  = count_t'(32);
    localparam count_t OFF_TARGET_IP   = count_t'(38);
    localparam count_t OFF_PAD         = count_t'(42);

    // Header byte values
    localparam logic [7:0] ETYPE_HI   = 8'h08;
    localparam logic [7:0] ETYPE_LO   = 8'h06;
    localparam logic [7:0] HTYPE_HI   = 8'h00;
    localparam logic [7:0] HTYPE_LO   = 8'h01;
    localparam logic [7:0] PTYPE_HI   = 8'h08;
    localparam logic [7:0] PTYPE_LO   = 8'h00;
    localparam logic [7:0] HLEN_ETH   = 8'd6;
    localparam logic [7:0] PLEN_IPV4  = 8'd4;
    localparam logic [7:0] OPER_HI    = 8'h00;
    localparam logic [7:0] OPER_REQ   = 8'h01;
    localparam logic [7:0] OPER_REPLY = 8'h02;

    typedef struct packed {
        logic       check;
        logic [7:0] value;
    } hdr_chk_t;

    // Fields captured from the request, held until the next frame
    typedef struct packed {
        logic [47:0] eth_src_mac;
        logic [47:0] sender_mac;
        logic [31:0] peer_ip;
    } req_fields_t;

    // End-of-frame verdict with the sender binding for the cache
    typedef struct packed {
        logic        accept;
        logic [47:0] sender_mac;
        logic [31:0] peer_ip;
    } frame_done_t;

    // Expected value at the fixed header offsets
    function automatic hdr_chk_t hdr_expected(input count_t idx);
        hdr_chk_t r;
        r.check = 1'b1;
        unique case (idx)
            OFF_ETYPE_HI: r.value = ETYPE_HI;
            OFF_ETYPE_LO: r.value = ETYPE_LO;
            OFF_HTYPE_HI: r.value = HTYPE_HI;
            OFF_HTYPE_LO: r.value = HTYPE_LO;
            OFF_PTYPE_HI: r.value = PTYPE_HI;
            OFF_PTYPE_LO: r.value = PTYPE_LO;
            OFF_HLEN:     r.value = HLEN_ETH;
            OFF_PLEN:     r.value = PLEN_IPV4;
            OFF_OPER_HI:  r.value = OPER_HI;
            OFF_OPER_LO:  r.value = OPER_REQ;
            default:
            begin
                r.check = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

    // Byte k of a MAC, most significant first
    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
        logic [5:0] base;
        base = 6'(8 * (5 - int'(k)));
        return mac[base +: 8];
    endfunction

    // Byte k of an IPv4 address, most significant first
    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
        logic [4:0] base;
        base = 5'(8 * (3 - int'(k)));
        return ip[base +: 8];
    endfunction

endpackage

[sv/arp_rx_parser.sv]
// ----------------------------------------------------------------------------
// arp_rx_parser
// Byte-serial receive parser: checks the ARP header, captures addresses and
// gives the accept verdict on the last byte of each frame.
// ----------------------------------------------------------------------------
module arp_rx_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_en,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    input  logic [31:0]          local_ip,
    output arp_pkg::req_fields_t fields,
    output arp_pkg::frame_done_t done
);
    import arp_pkg::*;

    count_t      byte_count_reg, byte_count_next;
    logic        header_ok_reg, header_ok_next;
    req_fields_t fields_reg, fields_next;
    logic [31:0] target_ip_reg, target_ip_next;
    hdr_chk_t    chk;
    count_t      idx;

    // Per-byte capture and header check
    always_comb
    begin
        idx             = byte_count_reg;
        fields_next     = fields_reg;
        target_ip_next  = target_ip_reg;
        header_ok_next  = header_ok_reg;
        byte_count_next = byte_count_reg;
        chk             = hdr_expected(idx);

        priority if (idx >= OFF_ETH_SRC && idx < OFF_ETYPE_HI)
            fields_next.eth_src_mac = {fields_reg.eth_src_mac[39:0], data_byte};
        else if (idx >= OFF_SENDER_MAC && idx < OFF_SENDER_IP)
            fields_next.sender_mac = {fields_reg.sender_mac[39:0], data_byte};
        else if (idx >= OFF_SENDER_IP && idx < OFF_TARGET_MAC)
            fields_next.peer_ip = {fields_reg.peer_ip[23:0], data_byte};
        else if (idx >= OFF_TARGET_IP && idx < OFF_PAD)
            target_ip_next = {target_ip_reg[23:0], data_byte};
        else
            fields_next = fields_reg;

        if (chk.check && chk.value != data_byte)
            header_ok_next = 1'b0;
        if (byte_count_reg != CNT_MAX)
            byte_count_next = byte_count_reg + count_t'(1);

        // Verdict uses the values including this byte
        done.accept     = byte_en && last_byte && header_ok_next
                          && byte_count_next >= MIN_FRAME_LEN
                          && target_ip_next == local_ip;
        done.sender_mac = fields_next.sender_mac;
        done.peer_ip    = fields_next.peer_ip;

        // End of frame restarts the parse
        if (last_byte)
        begin
            byte_count_next = '0;
            header_ok_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            header_ok_reg  <= 1'b1;
            fields_reg     <= '0;
            target_ip_reg  <= '0;
        end
        else if (byte_en)
        begin
            byte_count_reg <= byte_count_next;
            header_ok_reg  <= header_ok_next;
            fields_reg     <= fields_next;
            target_ip_reg  <= target_ip_next;
        end
    end

    assign fields = fields_reg;

endmodule

[sv/arp_cache.sv]
// ----------------------------------------------------------------------------
// arp_ip_binding
// One-entry IP to MAC binding, loaded by accepted requests and queried by
// lookup items.
// ----------------------------------------------------------------------------
module arp_ip_binding
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  arp_pkg::frame_done_t done,
    input  logic [31:0]          query_ip,
    output logic                 lookup_hit,
    output logic [47:0]          lookup_mac
);
    import arp_pkg::*;

    logic        valid_reg;
    logic [31:0] ip_reg;
    logic [47:0] mac_reg;

    // Load on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ip_reg    <= '0;
            mac_reg   <= '0;
        end
        else if (done.accept)
        begin
            valid_reg <= 1'b1;
            ip_reg    <= done.peer_ip;
            mac_reg   <= done.sender_mac;
        end
    end

    // Query compare
    assign lookup_hit = valid_reg && (ip_reg == query_ip);
    assign lookup_mac = lookup_hit ? mac_reg : 48'h0;

endmodule

[sv/arp_tx_gen.sv]
// ----------------------------------------------------------------------------
// arp_tx_gen
// Reply sequencer: walks a byte counter over the 60-byte reply frame and
// selects each byte from the captured request and the local address.
// ----------------------------------------------------------------------------
module arp_tx_gen
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 step,
    input  arp_pkg::req_fields_t fields,
    input  logic [31:0]          local_ip,
    input  logic [47:0]          local_mac,
    output logic                 busy,
    output logic [7:0]           tx_byte,
    output logic                 tx_last
);
    import arp_pkg::*;

    logic     busy_reg, busy_next;
    count_t   tx_count_reg, tx_count_next;
    hdr_chk_t hdr_val;

    // Counter and busy flag
    always_comb
    begin
        busy_next     = busy_reg;
        tx_count_next = tx_count_reg;
        if (start)
        begin
            busy_next     = 1'b1;
            tx_count_next = '0;
        end
        else if (busy_reg && step)
        begin
            tx_count_next = tx_count_reg + count_t'(1);
            if (tx_count_reg == REPLY_LAST_IDX)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            tx_count_reg <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            tx_count_reg <= tx_count_next;
        end
    end

    // Fixed header byte at the current offset
    assign hdr_val = hdr_expected(tx_count_reg);

    // Reply byte select
    always_comb
    begin
        priority if (tx_count_reg < OFF_ETH_SRC)
            tx_byte = mac_byte(fields.eth_src_mac, 3'(tx_count_reg - OFF_ETH_DST));
        else if (tx_count_reg < OFF_ETYPE_HI)
            tx_byte = mac_byte(local_mac, 3'(tx_count_reg - OFF_ETH_SRC));
        else if (tx_count_reg == OFF_OPER_LO)
            tx_byte = OPER_REPLY;
        else if (tx_count_reg < OFF_SENDER_MAC)
            tx_byte = hdr_val.value;
        else if (tx_count_reg < OFF_SENDER_IP)
            tx_byte = mac_byte(local_mac, 3'(tx_count_reg - OFF_SENDER_MAC));
        else if (tx_count_reg < OFF_TARGET_MAC)
            tx_byte = ip_byte(local_ip, 2'(tx_count_reg - OFF_SENDER_IP));
        else if (tx_count_reg < OFF_TARGET_IP)
            tx_byte = mac_byte(fields.sender_mac, 3'(tx_count_reg - OFF_TARGET_MAC));
        else if (tx_count_reg < OFF_PAD)
            tx_byte = ip_byte(fields.peer_ip, 2'(tx_count_reg - OFF_TARGET_IP));
        else
            tx_byte = 8'h00;
    end

    assign busy    = busy_reg;
    assign tx_last = (tx_count_reg == REPLY_LAST_IDX);

endmodule

[sv/arp_request_responder.sv]
// ----------------------------------------------------------------------------
// arp_request_responder
// Byte-serial ARP responder for IPv4 over Ethernet with a one-entry cache.
//
//   Channel  Handshake              Payload
//   req      req_valid/req_ready    req_type, data_byte, last_byte, query_ip
//   rsp      rsp_valid/rsp_ready    result_kind, reply_byte, reply_last,
//                                   lookup_hit, lookup_mac
//   cfg      cfg_valid/cfg_ready    cfg_index, cfg_data (always ready)
//
// Frame bytes and lookups are taken one per cycle while req_ready is high; a lookup answer appears
// in the output register the cycle after it is accepted.
// An accepted request starts a 60-word reply, one word per cycle when rsp is
// not stalled; req is held off while those words are loaded.
// req_ready also drops while a full output word is stalled.
// Reset clears the parser, the cache valid bit and both local registers.
// ----------------------------------------------------------------------------
module arp_request_responder
(
    input  logic                   clk,
    input  logic                   rst_n,
    // request channel
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic                   req_type,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  logic [31:0]            query_ip,
    // result channel
    output logic                   rsp_valid,
    input  logic                   rsp_ready,
    output logic                   result_kind,
    output logic [7:0]             reply_byte,
    output logic                   reply_last,
    output logic                   lookup_hit,
    output logic [47:0]            lookup_mac,
    // configuration channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  arp_pkg::cfg_idx_t      cfg_index,
    input  logic [47:0]            cfg_data
);
    import arp_pkg::*;

    logic        slot_free;
    logic        req_fire;
    logic        byte_en;
    logic        lookup_en;
    logic        tx_busy;
    logic        tx_step;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic        hit;
    logic [47:0] hit_mac;

    logic [31:0] local_ip_reg;
    logic [47:0] local_mac_reg;

    req_fields_t fields;
    frame_done_t done;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic        out_hit_reg;
    logic [47:0] out_mac_reg;

    // Handshake
    assign slot_free = !out_valid_reg || rsp_ready;
    assign req_ready = slot_free && !tx_busy;
    assign req_fire  = req_valid && req_ready;
    assign byte_en   = req_fire && (req_type == REQ_FRAME);
    assign lookup_en = req_fire && (req_type == REQ_LOOKUP);
    assign tx_step   = tx_busy && slot_free;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg  <= '0;
            local_mac_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_LOCAL_IP)
                local_ip_reg <= cfg_data[31:0];
            else if (cfg_index == REG_LOCAL_MAC)
                local_mac_reg <= cfg_data;
        end
    end

    arp_rx_parser u_rx
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .local_ip  (local_ip_reg),
        .fields    (fields),
        .done      (done)
    );

    arp_ip_binding u_cache
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .done       (done),
        .query_ip   (query_ip),
        .lookup_hit (hit),
        .lookup_mac (hit_mac)
    );

    arp_tx_gen u_tx
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (done.accept),
        .step      (tx_step),
        .fields    (fields),
        .local_ip  (local_ip_reg),
        .local_mac (local_mac_reg),
        .busy      (tx_busy),
        .tx_byte   (tx_byte),
        .tx_last   (tx_last)
    );

    // Output register: lookup answers and reply bytes never load together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_REPLY;
            out_byte_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_mac_reg   <= '0;
        end
        else if (lookup_en)
        begin
            out_valid_reg <= 1'b1;
            out_kind_reg  <= KIND_LOOKUP;
            out_byte_reg  <= 8'h00;
            out_last_reg  <= 1'b0;
            out_hit_reg   <= hit;
            out_mac_reg   <= hit_mac;
        end
        else if (tx_step)
        begin
            out_valid_reg <= 1'b1;
            out_kind_reg  <= KIND_REPLY;
            out_byte_reg  <= tx_byte;
            out_last_reg  <= tx_last;
            out_hit_reg   <= 1'b0;
            out_mac_reg   <= '0;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign result_kind = out_kind_reg;
    assign reply_byte  = out_byte_reg;
    assign reply_last  = out_last_reg;
    assign lookup_hit  = out_hit_reg;
    assign lookup_mac  = out_mac_reg;

endmodule
